/* rtl/core/pleth_window_normalizer_unit_assert.svh */
// ----------------------------------------------------------------------------
// pleth window normalizer assertion macros
// concurrent checks on aclk, held off during reset
// ----------------------------------------------------------------------------
`ifndef PLETH_WINDOW_NORMALIZER_UNIT_ASSERT_SVH
`define PLETH_WINDOW_NORMALIZER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define PWN_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("pleth window normalizer check failed");

// next-cycle implication
`define PWN_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("pleth window normalizer check failed");

`else

`define PWN_ASSERT_IMP(lbl, ante, cons)
`define PWN_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

/* rtl/core/pwn_pkg.sv */
// ----------------------------------------------------------------------------
// pwn_pkg
// sizes, constants and payload types of the pleth window normalizer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pwn_pkg;

    localparam int WINDOW_DEPTH = 256;
    localparam int ADDR_W       = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int SAMPLE_W     = 32;
    localparam int VALUE_W      = 7;
    localparam int PLETH_SCALE  = 100;
    // quotient never exceeds the scale, so seven quotient bits suffice
    localparam int QUOT_BITS    = VALUE_W;
    localparam int NUM_W        = SAMPLE_W + QUOT_BITS;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample_freq;
        logic                channel;
    } pwn_in_t;

    typedef struct packed {
        logic [VALUE_W-1:0] pleth_value;
        logic               pleth_valid;
        logic               flat_window;
        logic               out_channel;
    } pwn_out_t;

endpackage

/* rtl/core/pleth_window_normalizer_unit.sv */
// ----------------------------------------------------------------------------
// pleth_window_normalizer_unit
// sliding window min/max normalizer for tagged optical frequency samples
// ----------------------------------------------------------------------------
//
//  channel   dir   handshake          payload
//  s_        in    s_valid/s_ready    pwn_in_t  (sample_freq, channel)
//  m_        out   m_valid/m_ready    pwn_out_t (value, valid, flat, channel)
//
//  one sample at a time: the transfer cycle, then a scan of every window entry
//  through the single memory read port, a prep step, QUOT_BITS divide steps
//  and an output load step; a flat window skips the divider
//  reset is synchronous active low and holds s_ready low; no clearing pass,
//  entries not yet written read as zero through the fill count
//  a result waiting on m_ready holds the next sample only at the end of its work
//
`timescale 1ns / 1ps

module pleth_window_normalizer_unit (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  pwn_pkg::pwn_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output pwn_pkg::pwn_out_t m_data
);
    import pwn_pkg::*;

    `include "pleth_window_normalizer_unit_assert.svh"

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_PREP,
        ST_DIV,
        ST_OUT
    } state_t;

    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(WINDOW_DEPTH - 1);

    state_t              state_reg;

    // window memory and its fill tracking
    logic [SAMPLE_W-1:0] window_mem [WINDOW_DEPTH];
    logic [ADDR_W-1:0]   wp_reg;
    logic                full_reg;

    // scan read pipeline
    logic [ADDR_W-1:0]   rd_addr_reg;
    logic                rd_issue_reg;
    logic                rd_vld_reg;
    logic [ADDR_W-1:0]   rd_idx_reg;
    logic [SAMPLE_W-1:0] rd_data_reg;
    logic [SAMPLE_W-1:0] rd_value;

    // per-sample work registers
    logic [SAMPLE_W-1:0] sample_reg;
    logic                chan_reg;
    logic                valid_bit_reg;
    logic                ir_toggle_reg;
    logic                red_toggle_reg;
    logic [SAMPLE_W-1:0] hi_reg;
    logic [SAMPLE_W-1:0] lo_reg;
    logic                flat_reg;

    // restoring divider
    logic [NUM_W-1:0]     rem_reg;
    logic [NUM_W-1:0]     den_sh_reg;
    logic [QUOT_BITS-1:0] quot_reg;
    logic [2:0]           div_cnt_reg;
    logic                 div_take;

    logic                 m_valid_reg;
    pwn_out_t             m_data_reg;
    logic                 s_xfer;

    // no transfer is taken while reset is held
    assign s_ready = aresetn && (state_reg == ST_IDLE);
    assign s_xfer  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // window write on transfer, scan read registered
    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            window_mem[wp_reg] <= s_data.sample_freq;
        end
        if (rd_issue_reg) begin
            rd_data_reg <= window_mem[rd_addr_reg];
        end
    end

    // entries past the fill point read as zero; the memory itself is not cleared
    assign rd_value = (full_reg || (rd_idx_reg < wp_reg)) ? rd_data_reg : '0;

    assign div_take = (rem_reg >= den_sh_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            wp_reg         <= '0;
            full_reg       <= 1'b0;
            rd_issue_reg   <= 1'b0;
            rd_vld_reg     <= 1'b0;
            ir_toggle_reg  <= 1'b0;
            red_toggle_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            // the output state reloads the register itself
            if (m_valid_reg && m_ready && (state_reg != ST_OUT)) begin
                m_valid_reg <= 1'b0;
            end

            // read pipeline runs on its own once started
            rd_vld_reg <= rd_issue_reg;
            rd_idx_reg <= rd_addr_reg;
            if (rd_issue_reg) begin
                if (rd_addr_reg == LAST_ADDR) begin
                    rd_issue_reg <= 1'b0;
                end else begin
                    rd_addr_reg <= rd_addr_reg + 1'b1;
                end
            end

            // running max and min, first entry seeds both
            if (rd_vld_reg) begin
                if (rd_idx_reg == '0) begin
                    hi_reg <= rd_value;
                    lo_reg <= rd_value;
                end else begin
                    if (rd_value > hi_reg) hi_reg <= rd_value;
                    if (rd_value < lo_reg) lo_reg <= rd_value;
                end
            end

            case (state_reg)
                ST_IDLE: begin
                    if (s_xfer) begin
                        sample_reg <= s_data.sample_freq;
                        chan_reg   <= s_data.channel;
                        // valid flag is the toggle before this sample
                        if (s_data.channel) begin
                            valid_bit_reg  <= red_toggle_reg;
                            red_toggle_reg <= ~red_toggle_reg;
                        end else begin
                            valid_bit_reg <= ir_toggle_reg;
                            ir_toggle_reg <= ~ir_toggle_reg;
                        end
                        // ring pointer wraps at any depth
                        if (wp_reg == LAST_ADDR) begin
                            wp_reg   <= '0;
                            full_reg <= 1'b1;
                        end else begin
                            wp_reg <= wp_reg + 1'b1;
                        end
                        rd_addr_reg  <= '0;
                        rd_issue_reg <= 1'b1;
                        state_reg    <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if (rd_vld_reg && (rd_idx_reg == LAST_ADDR)) begin
                        state_reg <= ST_PREP;
                    end
                end
                ST_PREP: begin
                    // numerator (max - sample) * scale, divisor aligned to top quotient bit
                    rem_reg     <= NUM_W'(hi_reg - sample_reg) * NUM_W'(PLETH_SCALE);
                    den_sh_reg  <= NUM_W'(hi_reg - lo_reg) << (QUOT_BITS - 1);
                    quot_reg    <= '0;
                    div_cnt_reg <= 3'(QUOT_BITS - 1);
                    flat_reg    <= (hi_reg == lo_reg);
                    if (hi_reg == lo_reg) begin
                        state_reg <= ST_OUT;
                    end else begin
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    // one quotient bit per cycle
                    if (div_take) begin
                        rem_reg <= rem_reg - den_sh_reg;
                    end
                    quot_reg   <= {quot_reg[QUOT_BITS-2:0], div_take};
                    den_sh_reg <= den_sh_reg >> 1;
                    if (div_cnt_reg == '0) begin
                        state_reg <= ST_OUT;
                    end else begin
                        div_cnt_reg <= div_cnt_reg - 1'b1;
                    end
                end
                ST_OUT: begin
                    // load the output register once it is free
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg             <= 1'b1;
                        m_data_reg.pleth_value  <= flat_reg ? '0 : quot_reg;
                        m_data_reg.pleth_valid  <= valid_bit_reg;
                        m_data_reg.flat_window  <= flat_reg;
                        m_data_reg.out_channel  <= chan_reg;
                        state_reg               <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // scan data only shows up while scanning
    `PWN_ASSERT_IMP(a_scan_data_in_scan, rd_vld_reg, state_reg == ST_SCAN)
    // a flat window never enters the divider
    `PWN_ASSERT_IMP(a_no_flat_divide, state_reg == ST_DIV, !flat_reg)
    // a transfer starts the scan at entry zero
    `PWN_ASSERT_NXT(a_xfer_starts_scan, s_xfer, rd_issue_reg && (rd_addr_reg == '0))
    // value stays in range
    `PWN_ASSERT_IMP(a_value_range, m_valid_reg, m_data_reg.pleth_value <= VALUE_W'(PLETH_SCALE))

endmodule
